// File: hdl/mesp_pkg.sv
// Shared types, constants and decode functions of the MIDI event stream parser.
`default_nettype none
package mesp_pkg;

    localparam int CAPTURED_BYTES_DEF = 4;
    localparam int OUT_BYTES = 4;
    localparam int VLQ_W = 28;

    // Status bytes with a fixed meaning.
    localparam logic [7:0] ST_SONG_POS = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL = 8'hF3;
    localparam logic [7:0] ST_META     = 8'hFF;

    // Upper nibbles of channel messages.
    localparam logic [3:0] NIB_NOTE_OFF  = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON   = 4'h9;
    localparam logic [3:0] NIB_POLY_AT   = 4'hA;
    localparam logic [3:0] NIB_CTRL      = 4'hB;
    localparam logic [3:0] NIB_PROGRAM   = 4'hC;
    localparam logic [3:0] NIB_CHAN_AT   = 4'hD;
    localparam logic [3:0] NIB_PITCH     = 4'hE;

    // Meta event types that the parser recognizes.
    localparam logic [7:0] MT_TEXT_LAST   = 8'h09;
    localparam logic [7:0] MT_CHAN_PREFIX = 8'h20;
    localparam logic [7:0] MT_PORT        = 8'h21;
    localparam logic [7:0] MT_END_TRACK   = 8'h2F;
    localparam logic [7:0] MT_TAG         = 8'h4B;
    localparam logic [7:0] MT_TEMPO       = 8'h51;
    localparam logic [7:0] MT_SMPTE       = 8'h54;
    localparam logic [7:0] MT_TIME_SIG    = 8'h58;
    localparam logic [7:0] MT_KEY_SIG     = 8'h59;
    localparam logic [7:0] MT_SEQ_SPEC    = 8'h7F;

    localparam logic [VLQ_W-1:0] LEN_TWO = VLQ_W'(2);
    localparam logic [VLQ_W-1:0] LEN_ONE = VLQ_W'(1);

    typedef enum logic [2:0] {
        PH_READY   = 3'd0,
        PH_DELTA   = 3'd1,
        PH_STATUS  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_MTYPE   = 3'd4,
        PH_MLEN    = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        EK_CHANNEL = 2'd0,
        EK_META    = 2'd1,
        EK_ERROR   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        SC_TWO,
        SC_ONE,
        SC_META,
        SC_OTHER
    } t_scls;

    typedef struct packed {
        t_kind                         kind;
        logic [7:0]                    status;
        logic [6:0]                    meta_type;
        logic [VLQ_W-1:0]              delta;
        logic [VLQ_W-1:0]              length;
        logic [OUT_BYTES-1:0][7:0]     payload;
    } t_event;

    function automatic t_scls f_status_class(input logic [7:0] b);
        t_scls c;
        case (b[7:4])
            NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_AT, NIB_CTRL, NIB_PITCH: c = SC_TWO;
            NIB_PROGRAM, NIB_CHAN_AT: c = SC_ONE;
            default: begin
                if (b == ST_SONG_POS) begin
                    c = SC_TWO;
                end else if (b == ST_SONG_SEL) begin
                    c = SC_ONE;
                end else if (b == ST_META) begin
                    c = SC_META;
                end else begin
                    c = SC_OTHER;
                end
            end
        endcase
        return c;
    endfunction

    function automatic logic f_known_meta(input logic [7:0] t);
        logic k;
        case (t)
            MT_CHAN_PREFIX, MT_PORT, MT_END_TRACK, MT_TAG, MT_TEMPO,
            MT_SMPTE, MT_TIME_SIG, MT_KEY_SIG, MT_SEQ_SPEC: k = 1'b1;
            default: k = (t <= MT_TEXT_LAST);
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

// File: hdl/mesp_in_stage.sv
// Input register that holds one raw stream byte until the parser takes it.
`default_nettype none
module mesp_in_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_take,
    output logic            o_valid,
    output logic [7:0]      o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_data_byte;
        end
    end

endmodule
`default_nettype wire

// File: hdl/mesp_core.sv
// Parser state machine and event assembly, one byte per step.
`default_nettype none
module mesp_core #(
    parameter int CAPTURED_BYTES = mesp_pkg::CAPTURED_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_smf_mode,
    output logic            o_emit,
    output mesp_pkg::t_event o_event
);

    localparam int W = mesp_pkg::VLQ_W;

    mesp_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_status, n_status;
    logic [6:0]       r_meta, n_meta;
    logic [W-1:0]     r_vlq, n_vlq;
    logic [W-1:0]     r_delta, n_delta;
    logic [W-1:0]     r_expected, n_expected;
    logic [W-1:0]     r_received, n_received;
    logic [7:0]       r_capt [CAPTURED_BYTES];
    logic [7:0]       n_capt [CAPTURED_BYTES];
    logic [7:0]       w_pad  [mesp_pkg::OUT_BYTES];

    mesp_pkg::t_scls  w_cls;
    logic             w_b7;
    logic [W-1:0]     w_vlq_next;
    logic [W-1:0]     w_rcv_inc;
    logic             w_done;
    logic             w_known;
    logic             w_ready_like;
    logic             w_take;
    logic             w_fixed_len;

    assign w_b7        = i_byte[7];
    assign w_cls       = mesp_pkg::f_status_class(i_byte);
    assign w_known     = mesp_pkg::f_known_meta(i_byte);
    assign w_vlq_next  = {r_vlq[W-8:0], i_byte[6:0]};
    assign w_rcv_inc   = r_received + W'(1);
    assign w_done      = (w_rcv_inc >= r_expected);
    assign w_ready_like = (r_phase != mesp_pkg::PH_DELTA) && (r_phase != mesp_pkg::PH_STATUS)
                       && (r_phase != mesp_pkg::PH_PAYLOAD) && (r_phase != mesp_pkg::PH_MTYPE)
                       && (r_phase != mesp_pkg::PH_MLEN);
    // A status byte is taken either right after the delta time or, outside
    // file mode, as the first byte of an event.
    assign w_take      = (r_phase == mesp_pkg::PH_STATUS) || (w_ready_like && !i_smf_mode);
    assign w_fixed_len = w_b7 && ((w_cls == mesp_pkg::SC_TWO) || (w_cls == mesp_pkg::SC_ONE));

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            mesp_pkg::PH_DELTA: begin
                n_phase = w_b7 ? mesp_pkg::PH_DELTA : mesp_pkg::PH_STATUS;
            end
            mesp_pkg::PH_PAYLOAD: begin
                n_phase = w_done ? mesp_pkg::PH_READY : mesp_pkg::PH_PAYLOAD;
            end
            mesp_pkg::PH_MTYPE: begin
                n_phase = w_known ? mesp_pkg::PH_MLEN : mesp_pkg::PH_MTYPE;
            end
            mesp_pkg::PH_MLEN: begin
                if (!w_b7) begin
                    n_phase = (w_vlq_next != '0) ? mesp_pkg::PH_PAYLOAD : mesp_pkg::PH_READY;
                end
            end
            mesp_pkg::PH_STATUS: begin
                if (w_fixed_len) begin
                    n_phase = mesp_pkg::PH_PAYLOAD;
                end else if (w_b7 && (w_cls == mesp_pkg::SC_META)) begin
                    n_phase = mesp_pkg::PH_MTYPE;
                end
            end
            default: begin
                if (i_smf_mode) begin
                    n_phase = w_b7 ? mesp_pkg::PH_DELTA : mesp_pkg::PH_STATUS;
                end else if (w_fixed_len) begin
                    n_phase = mesp_pkg::PH_PAYLOAD;
                end else if (w_b7 && (w_cls == mesp_pkg::SC_META)) begin
                    n_phase = mesp_pkg::PH_MTYPE;
                end else begin
                    n_phase = mesp_pkg::PH_READY;
                end
            end
        endcase
    end

    // Payload capture slots.
    always_comb begin
        for (int i = 0; i < CAPTURED_BYTES; i++) begin
            n_capt[i] = r_capt[i];
        end
        case (r_phase)
            mesp_pkg::PH_PAYLOAD: begin
                for (int i = 0; i < CAPTURED_BYTES; i++) begin
                    if (r_received == W'(i)) begin
                        n_capt[i] = i_byte;
                    end
                end
            end
            mesp_pkg::PH_MTYPE, mesp_pkg::PH_MLEN: begin
                if ((r_phase == mesp_pkg::PH_MTYPE) ? w_known : !w_b7) begin
                    for (int i = 0; i < CAPTURED_BYTES; i++) begin
                        n_capt[i] = '0;
                    end
                end
            end
            default: begin
                if (w_take && w_fixed_len) begin
                    for (int i = 0; i < CAPTURED_BYTES; i++) begin
                        n_capt[i] = '0;
                    end
                end
            end
        endcase
    end

    for (genvar g = 0; g < mesp_pkg::OUT_BYTES; g++) begin : g_pad
        if (g < CAPTURED_BYTES) begin : g_slot
            assign w_pad[g] = n_capt[g];
        end else begin : g_none
            assign w_pad[g] = '0;
        end
    end

    // Scalar state updates and the event that a step completes.
    always_comb begin
        n_status   = r_status;
        n_meta     = r_meta;
        n_vlq      = r_vlq;
        n_delta    = r_delta;
        n_expected = r_expected;
        n_received = r_received;
        o_emit     = 1'b0;
        o_event    = '0;
        case (r_phase)
            mesp_pkg::PH_DELTA: begin
                n_vlq = w_vlq_next;
                if (!w_b7) begin
                    n_delta = w_vlq_next;
                end
            end
            mesp_pkg::PH_STATUS: begin
            end
            mesp_pkg::PH_PAYLOAD: begin
                n_received = w_rcv_inc;
                if (w_done) begin
                    o_emit         = 1'b1;
                    o_event.kind   = (r_status == mesp_pkg::ST_META) ? mesp_pkg::EK_META
                                                                      : mesp_pkg::EK_CHANNEL;
                    o_event.status = r_status;
                    o_event.meta_type = (r_status == mesp_pkg::ST_META) ? r_meta : '0;
                    o_event.delta  = r_delta;
                    o_event.length = w_rcv_inc;
                    for (int i = 0; i < mesp_pkg::OUT_BYTES; i++) begin
                        o_event.payload[i] = w_pad[i];
                    end
                end
            end
            mesp_pkg::PH_MTYPE: begin
                n_meta = i_byte[6:0];
                if (w_known) begin
                    n_vlq      = '0;
                    n_received = '0;
                end
            end
            mesp_pkg::PH_MLEN: begin
                n_vlq = w_vlq_next;
                if (!w_b7) begin
                    n_expected = w_vlq_next;
                    n_received = '0;
                    if (w_vlq_next == '0) begin
                        o_emit            = 1'b1;
                        o_event.kind      = mesp_pkg::EK_META;
                        o_event.status    = r_status;
                        o_event.meta_type = r_meta;
                        o_event.delta     = r_delta;
                    end
                end
            end
            default: begin
                n_status = '0;
                n_meta   = '0;
                n_delta  = '0;
                if (i_smf_mode) begin
                    n_vlq = {{(W-7){1'b0}}, i_byte[6:0]};
                    if (!w_b7) begin
                        n_delta = {{(W-7){1'b0}}, i_byte[6:0]};
                    end
                end
            end
        endcase
        if (w_take) begin
            if (!w_b7) begin
                n_status      = '0;
                o_emit        = 1'b1;
                o_event.kind  = mesp_pkg::EK_ERROR;
                o_event.delta = n_delta;
            end else begin
                n_status = i_byte;
                if (w_fixed_len) begin
                    n_expected = (w_cls == mesp_pkg::SC_TWO) ? mesp_pkg::LEN_TWO
                                                              : mesp_pkg::LEN_ONE;
                    n_received = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= mesp_pkg::PH_READY;
            r_status   <= '0;
            r_meta     <= '0;
            r_vlq      <= '0;
            r_delta    <= '0;
            r_expected <= '0;
            r_received <= '0;
            for (int i = 0; i < CAPTURED_BYTES; i++) begin
                r_capt[i] <= '0;
            end
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_status   <= n_status;
            r_meta     <= n_meta;
            r_vlq      <= n_vlq;
            r_delta    <= n_delta;
            r_expected <= n_expected;
            r_received <= n_received;
            for (int i = 0; i < CAPTURED_BYTES; i++) begin
                r_capt[i] <= n_capt[i];
            end
        end
    end

`ifndef NO_ASSERTIONS
    // A completed channel or meta event always returns the parser to a new event.
    a_done_to_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_emit && (o_event.kind != mesp_pkg::EK_ERROR))
        |=> (r_phase == mesp_pkg::PH_READY))
        else $error("completed event did not return to ready");

    // While payload bytes are pending the count stays below the expected length.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == mesp_pkg::PH_PAYLOAD) |-> (r_received < r_expected))
        else $error("payload count reached its length inside the payload phase");

    // Outside file mode no delta time is read and no status wait is entered.
    a_live_no_delta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && w_ready_like && !i_smf_mode)
        |=> ((r_phase != mesp_pkg::PH_DELTA) && (r_phase != mesp_pkg::PH_STATUS)))
        else $error("live stream entered a file-mode phase");
`endif

endmodule
`default_nettype wire

// File: hdl/mesp_out_stage.sv
// Result register that holds one completed event until the consumer takes it.
`default_nettype none
module mesp_out_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire mesp_pkg::t_event i_event,
    input  wire logic             i_ready,
    output logic                  o_space,
    output logic                  o_valid,
    output mesp_pkg::t_event      o_event
);

    logic             r_valid;
    mesp_pkg::t_event r_event;

    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_event = r_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_event <= i_event;
        end
    end

endmodule
`default_nettype wire

// File: hdl/midi_event_stream_parser_top.sv
// Top level of the MIDI event stream parser: byte input, event output, mode register.
`default_nettype none
// Channel   Direction  Handshake           Beat contents
// input     in         i_valid / o_ready   i_data_byte: one raw MIDI byte
// output    out        o_valid / i_ready   o_event_kind .. o_payload_byte3: one event
// config    in         i_cfg_we            i_cfg_data: smf_mode, no wait, no read-back
//
// An accepted byte waits in the input register until the parser step takes it, and
// its event, if any, is then loaded into the result register that drives the output.
// The parser step is a single pass of short logic between the input register and
// the result register, so sustained throughput is one byte per cycle unless the output stalls.
// Reset is synchronous and active low; it clears the parser to wait for a new event
// and drops both valid flags. A stalled output holds its event; the parser step and
// the input register stall only while the result register is still full.
module midi_event_stream_parser_top #(
    parameter int CAPTURED_BYTES = mesp_pkg::CAPTURED_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_event_kind,
    output logic [7:0]       o_status_byte,
    output logic [6:0]       o_meta_type,
    output logic [27:0]      o_delta_time,
    output logic [27:0]      o_payload_length,
    output logic [7:0]       o_payload_byte0,
    output logic [7:0]       o_payload_byte1,
    output logic [7:0]       o_payload_byte2,
    output logic [7:0]       o_payload_byte3,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_data
);

    // File mode: each event is preceded by a delta time.
    logic r_smf_mode;

    logic             w_in_valid;
    logic [7:0]       w_in_byte;
    logic             w_space;
    logic             w_step;
    logic             w_emit;
    mesp_pkg::t_event w_event;
    mesp_pkg::t_event w_out_event;

    // A byte steps the parser only when the result register can take whatever it makes.
    assign w_step = w_in_valid && w_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smf_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_smf_mode <= i_cfg_data;
        end
    end

    mesp_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_take      (w_step),
        .o_valid     (w_in_valid),
        .o_byte      (w_in_byte)
    );

    mesp_core #(
        .CAPTURED_BYTES (CAPTURED_BYTES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_byte     (w_in_byte),
        .i_smf_mode (r_smf_mode),
        .o_emit     (w_emit),
        .o_event    (w_event)
    );

    mesp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_step && w_emit),
        .i_event (w_event),
        .i_ready (i_ready),
        .o_space (w_space),
        .o_valid (o_valid),
        .o_event (w_out_event)
    );

    // Unpack the held event onto the individual field ports.
    assign o_event_kind     = w_out_event.kind;
    assign o_status_byte    = w_out_event.status;
    assign o_meta_type      = w_out_event.meta_type;
    assign o_delta_time     = w_out_event.delta;
    assign o_payload_length = w_out_event.length;
    assign o_payload_byte0  = w_out_event.payload[0];
    assign o_payload_byte1  = w_out_event.payload[1];
    assign o_payload_byte2  = w_out_event.payload[2];
    assign o_payload_byte3  = w_out_event.payload[3];

endmodule
`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench of the MIDI event stream parser: directed and random byte streams, scoreboard check.
`timescale 1ns / 100ps

module testbench;
    import mesp_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int CAPT         = CAPTURED_BYTES_DEF;
    // A byte passes the input and result registers before its event is on the output;
    // the margin also lets a byte that causes no event pass the parser.
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 400000;
    // Useful bytes per random chunk; six chunks give about 1300 bytes.
    localparam int CHUNK_BYTES  = 217;

    // One completed event as the parser reports it.
    typedef struct packed {
        t_kind            kind;
        logic [7:0]       status;
        logic [6:0]       meta_type;
        logic [27:0]      delta;
        logic [27:0]      length;
        logic [3:0][7:0]  payload;
    } midi_event_t;

    // Shadow parser: it follows every accepted byte and keeps the events that
    // the block must report, oldest first.
    class midi_event_scoreboard;
        logic             smf_mode;
        t_phase           phase;
        logic [7:0]       cur_status;
        logic [7:0]       cur_meta;
        logic [27:0]      vlv_acc;
        logic [27:0]      held_delta;
        logic [27:0]      want_len;
        logic [27:0]      got_len;
        logic [7:0]       kept [CAPT];
        midi_event_t      pending_events [$];
        int               fail_count;

        function new();
            smf_mode   = 1'b0;
            phase      = PH_READY;
            cur_status = '0;
            cur_meta   = '0;
            vlv_acc    = '0;
            held_delta = '0;
            want_len   = '0;
            got_len    = '0;
            foreach (kept[i]) kept[i] = '0;
            fail_count = 0;
        endfunction

        function bit is_known_meta(logic [7:0] t);
            return (t <= MT_TEXT_LAST) || (t == MT_CHAN_PREFIX) || (t == MT_PORT)
                || (t == MT_END_TRACK) || (t == MT_TAG) || (t == MT_TEMPO)
                || (t == MT_SMPTE) || (t == MT_TIME_SIG) || (t == MT_KEY_SIG)
                || (t == MT_SEQ_SPEC);
        endfunction

        // Returns 1 when the byte closes the variable-length value.
        function bit feed_vlv(logic [7:0] b);
            vlv_acc = {vlv_acc[20:0], b[6:0]};
            return !b[7];
        endfunction

        function void start_payload(logic [27:0] len);
            want_len = len;
            got_len  = '0;
            foreach (kept[i]) kept[i] = '0;
            phase = PH_PAYLOAD;
        endfunction

        function void push_event(t_kind kind);
            midi_event_t e;
            e.kind      = kind;
            e.status    = (kind == EK_ERROR) ? 8'h00 : cur_status;
            e.meta_type = (kind == EK_META) ? cur_meta[6:0] : 7'd0;
            e.delta     = held_delta;
            e.length    = (kind == EK_ERROR) ? 28'd0 : got_len;
            for (int i = 0; i < 4; i++) begin
                if (kind != EK_ERROR && i < CAPT && i < got_len) begin
                    e.payload[i] = kept[i];
                end else begin
                    e.payload[i] = 8'h00;
                end
            end
            pending_events.push_back(e);
        endfunction

        // Returns 1 when the byte was not a status byte and an error event was noted.
        function bit take_status(logic [7:0] b);
            phase = PH_STATUS;
            if (!b[7]) begin
                cur_status = 8'h00;
                push_event(EK_ERROR);
                return 1'b1;
            end
            cur_status = b;
            case (b[7:4])
                NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_AT, NIB_CTRL, NIB_PITCH: begin
                    start_payload(LEN_TWO);
                end
                NIB_PROGRAM, NIB_CHAN_AT: begin
                    start_payload(LEN_ONE);
                end
                default: begin
                    if (b == ST_SONG_POS) begin
                        start_payload(LEN_TWO);
                    end else if (b == ST_SONG_SEL) begin
                        start_payload(LEN_ONE);
                    end else if (b == ST_META) begin
                        phase = PH_MTYPE;
                    end
                end
            endcase
            return 1'b0;
        endfunction

        // Notes one accepted input beat.
        function void note_byte(logic [7:0] b);
            bit was_error;
            case (phase)
                PH_DELTA: begin
                    if (feed_vlv(b)) begin
                        held_delta = vlv_acc;
                        phase = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    void'(take_status(b));
                end
                PH_PAYLOAD: begin
                    if (got_len < CAPT) kept[got_len] = b;
                    got_len = got_len + 28'd1;
                    if (got_len >= want_len) begin
                        push_event((cur_status == ST_META) ? EK_META : EK_CHANNEL);
                        phase = PH_READY;
                    end
                end
                PH_MTYPE: begin
                    cur_meta = b;
                    if (is_known_meta(b)) begin
                        vlv_acc = '0;
                        got_len = '0;
                        foreach (kept[i]) kept[i] = '0;
                        phase = PH_MLEN;
                    end
                end
                PH_MLEN: begin
                    if (feed_vlv(b)) begin
                        if (vlv_acc != 28'd0) begin
                            start_payload(vlv_acc);
                        end else begin
                            want_len = '0;
                            got_len  = '0;
                            push_event(EK_META);
                            phase = PH_READY;
                        end
                    end
                end
                default: begin
                    cur_status = '0;
                    cur_meta   = '0;
                    held_delta = '0;
                    if (smf_mode) begin
                        vlv_acc = '0;
                        phase = PH_DELTA;
                        if (feed_vlv(b)) begin
                            held_delta = vlv_acc;
                            phase = PH_STATUS;
                        end
                    end else begin
                        was_error = take_status(b);
                        if (was_error || phase == PH_STATUS) phase = PH_READY;
                    end
                end
            endcase
        endfunction

        task report_mismatch(string field, logic [27:0] got, logic [27:0] want);
            $display("MISMATCH %s: got 0x%0h, expected 0x%0h", field, got, want);
            fail_count++;
        endtask

        // Checks one accepted output beat against the oldest expected event.
        task check_event(logic [1:0] kind, logic [7:0] status, logic [6:0] meta,
                         logic [27:0] delta, logic [27:0] len, logic [7:0] p0,
                         logic [7:0] p1, logic [7:0] p2, logic [7:0] p3);
            midi_event_t want;
            if (pending_events.size() == 0) begin
                report_mismatch("event with none expected, status", status, 28'd0);
                return;
            end
            want = pending_events.pop_front();
            if (kind !== want.kind) report_mismatch("event_kind", kind, want.kind);
            if (status !== want.status) report_mismatch("status_byte", status, want.status);
            if (meta !== want.meta_type) report_mismatch("meta_type", meta, want.meta_type);
            if (delta !== want.delta) report_mismatch("delta_time", delta, want.delta);
            if (len !== want.length) report_mismatch("payload_length", len, want.length);
            if (p0 !== want.payload[0]) report_mismatch("payload_byte0", p0, want.payload[0]);
            if (p1 !== want.payload[1]) report_mismatch("payload_byte1", p1, want.payload[1]);
            if (p2 !== want.payload[2]) report_mismatch("payload_byte2", p2, want.payload[2]);
            if (p3 !== want.payload[3]) report_mismatch("payload_byte3", p3, want.payload[3]);
        endtask
    endclass

    // Every input of the block starts at a known value.
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_ready     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_data  = 1'b0;

    logic        o_ready;
    logic        o_valid;
    logic [1:0]  o_event_kind;
    logic [7:0]  o_status_byte;
    logic [6:0]  o_meta_type;
    logic [27:0] o_delta_time;
    logic [27:0] o_payload_length;
    logic [7:0]  o_payload_byte0;
    logic [7:0]  o_payload_byte1;
    logic [7:0]  o_payload_byte2;
    logic [7:0]  o_payload_byte3;

    // Idle rates in percent per cycle for the byte sender and the event receiver.
    int send_idle = 0;
    int recv_idle = 0;
    // Bytes sent so far, and those among them that the parser just drops.
    int stream_bytes  = 0;
    int ignored_bytes = 0;
    int cycle_count   = 0;

    midi_event_scoreboard sb = new();

    midi_event_stream_parser_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_event_kind     (o_event_kind),
        .o_status_byte    (o_status_byte),
        .o_meta_type      (o_meta_type),
        .o_delta_time     (o_delta_time),
        .o_payload_length (o_payload_length),
        .o_payload_byte0  (o_payload_byte0),
        .o_payload_byte1  (o_payload_byte1),
        .o_payload_byte2  (o_payload_byte2),
        .o_payload_byte3  (o_payload_byte3),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // The run is cut off if the block stops answering.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // The receiver drops ready at random; the draw is made at the falling
    // edge so that the value is stable at the next rising edge.
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Every event beat taken at a rising edge goes to the scoreboard. The
    // values read here are the ones from before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_event(o_event_kind, o_status_byte, o_meta_type, o_delta_time,
                           o_payload_length, o_payload_byte0, o_payload_byte1,
                           o_payload_byte2, o_payload_byte3);
        end
    end

    // Offers one byte and returns at the falling edge after its beat was taken.
    // Valid stays high from one byte to the next unless the sender idles.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        sb.note_byte(b);
        stream_bytes++;
        @(negedge i_clk);
    endtask

    // Stops the byte stream and waits until every expected event has arrived
    // and the last bytes have passed the parser.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sb.pending_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // The mode register is only written while the parser has nothing in flight.
    task automatic write_mode(input logic mode);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= mode;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.smf_mode = mode;
    endtask

    // Data bytes mostly have bit 7 clear, as in a real stream.
    function automatic logic [7:0] random_data_byte();
        if ($urandom_range(0, 99) < 85) return 8'($urandom_range(0, 127));
        return 8'($urandom_range(0, 255));
    endfunction

    // Sends one well-formed event with random content, sometimes preceded by
    // stray data bytes or ignored statuses, or else a short burst of noise.
    task automatic send_event();
        int          pick;
        logic [7:0]  b;
        logic [27:0] len;
        // First close whatever noise left open, so that the next event is
        // parsed from its start and a wild meta length cannot swallow the run.
        while (sb.phase inside {PH_DELTA, PH_MTYPE, PH_MLEN, PH_PAYLOAD}) begin
            case (sb.phase)
                PH_DELTA, PH_MLEN: send_byte(8'h00);
                PH_MTYPE:          send_byte(MT_END_TRACK);
                default:           send_byte(random_data_byte());
            endcase
        end
        // In file mode the delta time comes first: mostly one byte, sometimes
        // several, and now and then more than four so the top bits drop out.
        if (sb.phase == PH_READY && sb.smf_mode) begin
            pick = $urandom_range(0, 99);
            pick = (pick < 70) ? 1 : (pick < 92) ? $urandom_range(2, 4) : $urandom_range(5, 6);
            repeat (pick - 1) send_byte(8'h80 | 8'($urandom_range(0, 127)));
            send_byte(8'($urandom_range(0, 127)));
        end
        // A data byte where a status belongs gives an error event; an unknown
        // status or a system exclusive is dropped. Neither asks for a new delta.
        if ($urandom_range(0, 99) < 12) begin
            repeat ($urandom_range(1, 2)) begin
                if ($urandom_range(0, 1)) begin
                    send_byte(8'($urandom_range(0, 127)));
                end else begin
                    do b = 8'hF0 + 8'($urandom_range(0, 14));
                    while (b == ST_SONG_POS || b == ST_SONG_SEL);
                    send_byte(b);
                    ignored_bytes++;
                end
            end
        end
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            case ($urandom_range(0, 4))
                0:       b = {NIB_NOTE_OFF, 4'($urandom_range(0, 15))};
                1:       b = {NIB_NOTE_ON, 4'($urandom_range(0, 15))};
                2:       b = {NIB_POLY_AT, 4'($urandom_range(0, 15))};
                3:       b = {NIB_CTRL, 4'($urandom_range(0, 15))};
                default: b = {NIB_PITCH, 4'($urandom_range(0, 15))};
            endcase
            send_byte(b);
            send_byte(random_data_byte());
            send_byte(random_data_byte());
        end else if (pick < 60) begin
            if ($urandom_range(0, 1)) begin
                send_byte({NIB_PROGRAM, 4'($urandom_range(0, 15))});
            end else begin
                send_byte({NIB_CHAN_AT, 4'($urandom_range(0, 15))});
            end
            send_byte(random_data_byte());
        end else if (pick < 66) begin
            if ($urandom_range(0, 1)) begin
                send_byte(ST_SONG_POS);
                send_byte(random_data_byte());
            end else begin
                send_byte(ST_SONG_SEL);
            end
            send_byte(random_data_byte());
        end else if (pick < 92) begin
            send_byte(ST_META);
            // Unknown meta types are skipped and the next byte is a type again.
            if ($urandom_range(0, 99) < 20) begin
                repeat ($urandom_range(1, 2)) begin
                    do b = 8'($urandom_range(0, 255));
                    while (sb.is_known_meta(b));
                    send_byte(b);
                    ignored_bytes++;
                end
            end
            if ($urandom_range(0, 1)) begin
                b = 8'($urandom_range(0, MT_TEXT_LAST));
            end else begin
                case ($urandom_range(0, 8))
                    0:       b = MT_CHAN_PREFIX;
                    1:       b = MT_PORT;
                    2:       b = MT_END_TRACK;
                    3:       b = MT_TAG;
                    4:       b = MT_TEMPO;
                    5:       b = MT_SMPTE;
                    6:       b = MT_TIME_SIG;
                    7:       b = MT_KEY_SIG;
                    default: b = MT_SEQ_SPEC;
                endcase
            end
            send_byte(b);
            pick = $urandom_range(0, 99);
            len = (pick < 20) ? 28'd0 : (pick < 85) ? 28'($urandom_range(1, 6))
                                                    : 28'($urandom_range(7, 12));
            // Sometimes the length comes in a long form with leading groups
            // beyond 28 bits, which the parser must drop.
            if ($urandom_range(0, 99) < 10) begin
                repeat ($urandom_range(1, 2)) send_byte(8'h80 | 8'($urandom_range(1, 127)));
                send_byte({1'b1, len[27:21]});
                send_byte({1'b1, len[20:14]});
                send_byte({1'b1, len[13:7]});
                send_byte({1'b0, len[6:0]});
            end else begin
                send_byte({1'b0, len[6:0]});
            end
            repeat (len) send_byte(random_data_byte());
        end else begin
            // Noise: any byte at all, except that a meta length is kept short.
            repeat ($urandom_range(1, 3)) begin
                b = 8'($urandom_range(0, 255));
                if (sb.phase == PH_MLEN) b = b & 8'h0F;
                send_byte(b);
            end
        end
    endtask

    initial begin
        logic [7:0] live_bytes [$];
        logic [7:0] file_bytes [$];
        int         target;

        // Stream mode: a note on, a song position, a stray data byte, a
        // dropped system exclusive before a program change with a high data
        // byte, then an unknown meta type before a zero-length end of track.
        live_bytes = '{8'h90, 8'h3C, 8'h7F,
                       ST_SONG_POS, 8'h7F, 8'h00,
                       8'h12,
                       8'hF0, 8'hC5, 8'hFF,
                       ST_META, 8'h30, MT_END_TRACK, 8'h00};
        // File mode: a five-byte delta whose top bits drop out, a stray data
        // byte that keeps that delta, a song select; then the largest delta
        // before a tempo meta event with more payload than is captured.
        file_bytes = '{8'h81, 8'h80, 8'h80, 8'h80, 8'h01,
                       8'h55,
                       ST_SONG_SEL, 8'h7F,
                       8'hFF, 8'hFF, 8'hFF, 8'h7F,
                       ST_META, MT_TEMPO, 8'h05, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05};

        // Synchronous reset, held low at the start of the run.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle = 6;
        recv_idle = 75;
        write_mode(1'b0);
        foreach (live_bytes[i]) send_byte(live_bytes[i]);
        write_mode(1'b1);
        foreach (file_bytes[i]) send_byte(file_bytes[i]);

        // Random part in three idle settings: a slow receiver, a slow sender,
        // then full rate on both sides. Each setting runs both modes.
        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    send_idle = 6;
                    recv_idle = 75;
                end
                1: begin
                    send_idle = 75;
                    recv_idle = 6;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            for (int s = 0; s < 2; s++) begin
                write_mode(((p + s) % 2) == 0);
                target = stream_bytes - ignored_bytes + CHUNK_BYTES;
                while (stream_bytes - ignored_bytes < target) send_event();
            end
        end

        wait_idle();
        if (sb.fail_count == 0 && sb.pending_events.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
